>>> rtl/core/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and controller/datapath interface types for the
// buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGE_SHIFT_DEF = 12;
    localparam int TOP_ORDER_DEF  = 20;

    localparam int SIZE_W     = 21;
    localparam int OFF_W      = 20;
    localparam int STAT_W     = 2;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

    localparam logic [1:0] PG_NONE = 2'd0;
    localparam logic [1:0] PG_FREE = 2'd1;
    localparam logic [1:0] PG_USED = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_SRCH_STEP,
        OP_TAKE,
        OP_ULK_RD,
        OP_ULK_WR,
        OP_SPLIT,
        OP_GRANT,
        OP_PSH_SOLO,
        OP_PSH_RD,
        OP_PSH_WR1,
        OP_PSH_WR2,
        OP_INFO_RD,
        OP_FREE_BEGIN,
        OP_BUD_RD,
        OP_MERGE,
        OP_MERGE_UP,
        OP_FREE_PUSH,
        OP_FAIL1,
        OP_FAIL2
    } bpa_op_t;

    typedef struct packed {
        bpa_op_t op;
    } bpa_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic oversize;
        logic bad_fmt;
        logic rel_empty;
        logic rel_last;
        logic c_gt_req;
        logic c_lt_top;
        logic pg_used;
        logic buddy_ok;
    } bpa_stat_t;

endpackage

>>> rtl/core/bpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for the allocator: issues at most one datapath command per
// cycle, none while the result waits to be taken; runs the stream handshakes.
// ----------------------------------------------------------------------------
module bpa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output bpa_pkg::bpa_cmd_t  cmd,
    input  bpa_pkg::bpa_stat_t stat
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_ULK_RD,
        S_ULK_WR,
        S_SPLIT_CHK,
        S_PSH,
        S_PSH_WR1,
        S_PSH_WR2,
        S_CHKUSED,
        S_BUD,
        S_BUD_CHK,
        S_MERGE_UP,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // after a push, allocation returns to the split loop, a free is done
    state_t push_ret;

    assign push_ret  = stat.is_free ? S_OUT : S_SPLIT_CHK;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bpa_pkg::OP_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = bpa_pkg::OP_CLEAR;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = bpa_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.is_free)
                begin
                    if (stat.oversize)
                    begin
                        cmd.op     = bpa_pkg::OP_FAIL1;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_SEARCH;
                end
                else if (stat.bad_fmt)
                begin
                    cmd.op     = bpa_pkg::OP_FAIL2;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_INFO_RD;
                    state_next = S_CHKUSED;
                end
            end
            S_SEARCH:
            begin
                if (!stat.rel_empty)
                begin
                    cmd.op     = bpa_pkg::OP_TAKE;
                    state_next = S_ULK_RD;
                end
                else if (stat.rel_last)
                begin
                    cmd.op     = bpa_pkg::OP_FAIL1;
                    state_next = S_OUT;
                end
                else
                    cmd.op = bpa_pkg::OP_SRCH_STEP;
            end
            S_ULK_RD:
            begin
                cmd.op     = bpa_pkg::OP_ULK_RD;
                state_next = S_ULK_WR;
            end
            S_ULK_WR:
            begin
                cmd.op     = bpa_pkg::OP_ULK_WR;
                state_next = stat.is_free ? S_MERGE_UP : S_SPLIT_CHK;
            end
            S_SPLIT_CHK:
            begin
                if (stat.c_gt_req)
                begin
                    cmd.op     = bpa_pkg::OP_SPLIT;
                    state_next = S_PSH;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_GRANT;
                    state_next = S_OUT;
                end
            end
            S_PSH:
            begin
                if (stat.rel_empty)
                begin
                    cmd.op     = bpa_pkg::OP_PSH_SOLO;
                    state_next = push_ret;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_PSH_RD;
                    state_next = S_PSH_WR1;
                end
            end
            S_PSH_WR1:
            begin
                cmd.op     = bpa_pkg::OP_PSH_WR1;
                state_next = S_PSH_WR2;
            end
            S_PSH_WR2:
            begin
                cmd.op     = bpa_pkg::OP_PSH_WR2;
                state_next = push_ret;
            end
            S_CHKUSED:
            begin
                if (!stat.pg_used)
                begin
                    cmd.op     = bpa_pkg::OP_FAIL2;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_FREE_BEGIN;
                    state_next = S_BUD;
                end
            end
            S_BUD:
            begin
                if (stat.c_lt_top)
                begin
                    cmd.op     = bpa_pkg::OP_BUD_RD;
                    state_next = S_BUD_CHK;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_FREE_PUSH;
                    state_next = S_PSH;
                end
            end
            S_BUD_CHK:
            begin
                if (stat.buddy_ok)
                begin
                    cmd.op     = bpa_pkg::OP_MERGE;
                    state_next = S_ULK_RD;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_FREE_PUSH;
                    state_next = S_PSH;
                end
            end
            S_MERGE_UP:
            begin
                cmd.op     = bpa_pkg::OP_MERGE_UP;
                state_next = S_BUD;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/core/bpa_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_dpath
// Allocator datapath: free list heads, link and page info memories, and the
// working registers of one request.
// ----------------------------------------------------------------------------
module bpa_dpath
#(
    parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF,
    parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bpa_pkg::bpa_cmd_t           cmd,
    output bpa_pkg::bpa_stat_t          stat,
    input  logic                        in_type,
    input  logic [bpa_pkg::SIZE_W-1:0]  in_size,
    input  logic [bpa_pkg::OFF_W-1:0]   in_off,
    output logic [bpa_pkg::STAT_W-1:0]  out_status,
    output logic [bpa_pkg::OFF_W-1:0]   out_granted
);

    localparam int PGW     = TOP_ORDER - PAGE_SHIFT;
    localparam int NPAGES  = 1 << PGW;
    localparam int NORDERS = PGW + 1;
    localparam int ORDW    = $clog2(NORDERS);
    localparam int HW      = PGW + 1;
    localparam logic [HW-1:0]   HEAD_EMPTY = HW'(NPAGES);
    localparam logic [ORDW-1:0] ORD_TOP    = ORDW'(NORDERS - 1);

    // smallest order whose block holds the size, relative to the page order
    function automatic logic [ORDW-1:0] size_order(input logic [bpa_pkg::SIZE_W-1:0] sz);
        logic [ORDW-1:0] r;
        r = ORD_TOP;
        for (int k = NORDERS - 1; k >= 0; k--)
        begin
            if ((64'(1) << (k + PAGE_SHIFT)) >= 64'(sz))
                r = ORDW'(k);
        end
        return r;
    endfunction

    logic [PGW-1:0]  next_mem [NPAGES];
    logic [PGW-1:0]  prev_mem [NPAGES];
    logic [ORDW-1:0] ord_mem  [NPAGES];
    logic [1:0]      hst_mem  [NPAGES];

    logic [PGW-1:0]  next_rd, prev_rd;
    logic [ORDW-1:0] ord_rd;
    logic [1:0]      hst_rd;

    logic [HW-1:0]   heads_reg [NORDERS];
    logic [HW-1:0]   heads_next [NORDERS];
    logic [PGW-1:0]  clr_reg, clr_next;

    logic                       type_reg, type_next;
    logic                       ovs_reg, ovs_next;
    logic                       bad_reg, bad_next;
    logic [ORDW-1:0]            req_reg, req_next;
    logic [ORDW-1:0]            c_reg, c_next;
    logic [ORDW-1:0]            rel_reg, rel_next;
    logic [PGW-1:0]             pg_reg, pg_next;
    logic [PGW-1:0]             u_reg, u_next;
    logic [PGW-1:0]             pp_reg, pp_next;
    logic [PGW-1:0]             b_reg, b_next;
    logic [PGW-1:0]             h_reg, h_next;
    logic [PGW-1:0]             tl_reg, tl_next;
    logic [bpa_pkg::STAT_W-1:0] status_reg, status_next;
    logic [bpa_pkg::OFF_W-1:0]  granted_reg, granted_next;

    logic            next_we, prev_we, info_we;
    logic [PGW-1:0]  next_wa, next_wd, prev_wa, prev_wd, info_wa;
    logic [ORDW-1:0] ord_wd;
    logic [1:0]      hst_wd;
    logic [PGW-1:0]  prev_ra, info_ra;

    logic [HW-1:0]   head_sel;
    logic [PGW-1:0]  bud;
    logic [63:0]     off64;
    logic            off_bad;

    assign head_sel = heads_reg[rel_reg];
    assign bud      = pg_reg ^ (PGW'(1) << c_reg);
    assign off64    = 64'(in_off);
    assign off_bad  = ((off64 & ((64'(1) << PAGE_SHIFT) - 64'(1))) != 64'd0) ||
                      ((off64 >> PAGE_SHIFT) >= 64'(NPAGES));
    assign prev_ra  = (cmd.op == bpa_pkg::OP_PSH_RD) ? head_sel[PGW-1:0] : u_reg;
    assign info_ra  = (cmd.op == bpa_pkg::OP_BUD_RD) ? bud : pg_reg;

    always_comb
    begin
        heads_next   = heads_reg;
        clr_next     = clr_reg;
        type_next    = type_reg;
        ovs_next     = ovs_reg;
        bad_next     = bad_reg;
        req_next     = req_reg;
        c_next       = c_reg;
        rel_next     = rel_reg;
        pg_next      = pg_reg;
        u_next       = u_reg;
        pp_next      = pp_reg;
        b_next       = b_reg;
        h_next       = h_reg;
        tl_next      = tl_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        next_we      = 1'b0;
        next_wa      = '0;
        next_wd      = '0;
        prev_we      = 1'b0;
        prev_wa      = '0;
        prev_wd      = '0;
        info_we      = 1'b0;
        info_wa      = '0;
        ord_wd       = '0;
        hst_wd       = bpa_pkg::PG_NONE;
        case (cmd.op)
            bpa_pkg::OP_CLEAR:
            begin
                clr_next = clr_reg + PGW'(1);
                next_we  = 1'b1;
                next_wa  = clr_reg;
                prev_we  = 1'b1;
                prev_wa  = clr_reg;
                info_we  = 1'b1;
                info_wa  = clr_reg;
                if (clr_reg == '0)
                begin
                    ord_wd = ORD_TOP;
                    hst_wd = bpa_pkg::PG_FREE;
                end
            end
            bpa_pkg::OP_LOAD:
            begin
                type_next    = in_type;
                req_next     = size_order(in_size);
                rel_next     = size_order(in_size);
                ovs_next     = 64'(in_size) > (64'(1) << TOP_ORDER);
                bad_next     = off_bad;
                pg_next      = PGW'(off64 >> PAGE_SHIFT);
                status_next  = bpa_pkg::ST_OK;
                granted_next = '0;
            end
            bpa_pkg::OP_SRCH_STEP:
            begin
                rel_next = rel_reg + ORDW'(1);
            end
            bpa_pkg::OP_TAKE:
            begin
                pg_next = head_sel[PGW-1:0];
                u_next  = head_sel[PGW-1:0];
                c_next  = rel_reg;
            end
            bpa_pkg::OP_ULK_WR:
            begin
                // close the ring around the page, or empty the list
                if (next_rd == u_reg)
                    heads_next[rel_reg] = HEAD_EMPTY;
                else
                begin
                    next_we = 1'b1;
                    next_wa = prev_rd;
                    next_wd = next_rd;
                    prev_we = 1'b1;
                    prev_wa = next_rd;
                    prev_wd = prev_rd;
                    if (head_sel == HW'(u_reg))
                        heads_next[rel_reg] = HW'(next_rd);
                end
            end
            bpa_pkg::OP_SPLIT:
            begin
                c_next   = c_reg - ORDW'(1);
                rel_next = c_reg - ORDW'(1);
                b_next   = pg_reg ^ (PGW'(1) << (c_reg - ORDW'(1)));
                pp_next  = pg_reg ^ (PGW'(1) << (c_reg - ORDW'(1)));
                info_we  = 1'b1;
                info_wa  = pg_reg ^ (PGW'(1) << (c_reg - ORDW'(1)));
                ord_wd   = c_reg - ORDW'(1);
                hst_wd   = bpa_pkg::PG_FREE;
            end
            bpa_pkg::OP_GRANT:
            begin
                info_we      = 1'b1;
                info_wa      = pg_reg;
                ord_wd       = req_reg;
                hst_wd       = bpa_pkg::PG_USED;
                granted_next = bpa_pkg::OFF_W'(64'(pg_reg) << PAGE_SHIFT);
            end
            bpa_pkg::OP_PSH_SOLO:
            begin
                next_we             = 1'b1;
                next_wa             = pp_reg;
                next_wd             = pp_reg;
                prev_we             = 1'b1;
                prev_wa             = pp_reg;
                prev_wd             = pp_reg;
                heads_next[rel_reg] = HW'(pp_reg);
            end
            bpa_pkg::OP_PSH_RD:
            begin
                h_next = head_sel[PGW-1:0];
            end
            bpa_pkg::OP_PSH_WR1:
            begin
                next_we = 1'b1;
                next_wa = pp_reg;
                next_wd = h_reg;
                prev_we = 1'b1;
                prev_wa = pp_reg;
                prev_wd = prev_rd;
                tl_next = prev_rd;
            end
            bpa_pkg::OP_PSH_WR2:
            begin
                next_we             = 1'b1;
                next_wa             = tl_reg;
                next_wd             = pp_reg;
                prev_we             = 1'b1;
                prev_wa             = h_reg;
                prev_wd             = pp_reg;
                heads_next[rel_reg] = HW'(pp_reg);
            end
            bpa_pkg::OP_FREE_BEGIN:
            begin
                c_next  = (ord_rd > ORD_TOP) ? ORD_TOP : ord_rd;
                info_we = 1'b1;
                info_wa = pg_reg;
                ord_wd  = ord_rd;
                hst_wd  = bpa_pkg::PG_NONE;
            end
            bpa_pkg::OP_BUD_RD:
            begin
                b_next = bud;
            end
            bpa_pkg::OP_MERGE:
            begin
                info_we  = 1'b1;
                info_wa  = b_reg;
                ord_wd   = ord_rd;
                hst_wd   = bpa_pkg::PG_NONE;
                u_next   = b_reg;
                rel_next = c_reg;
            end
            bpa_pkg::OP_MERGE_UP:
            begin
                if (b_reg < pg_reg)
                    pg_next = b_reg;
                c_next = c_reg + ORDW'(1);
            end
            bpa_pkg::OP_FREE_PUSH:
            begin
                info_we  = 1'b1;
                info_wa  = pg_reg;
                ord_wd   = c_reg;
                hst_wd   = bpa_pkg::PG_FREE;
                pp_next  = pg_reg;
                rel_next = c_reg;
            end
            bpa_pkg::OP_FAIL1:
            begin
                status_next = bpa_pkg::ST_NOSPACE;
            end
            bpa_pkg::OP_FAIL2:
            begin
                status_next = bpa_pkg::ST_BADFREE;
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NORDERS; i++)
                heads_reg[i] <= (i == NORDERS - 1) ? '0 : HEAD_EMPTY;
            clr_reg <= '0;
        end
        else
        begin
            heads_reg <= heads_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg    <= type_next;
        ovs_reg     <= ovs_next;
        bad_reg     <= bad_next;
        req_reg     <= req_next;
        c_reg       <= c_next;
        rel_reg     <= rel_next;
        pg_reg      <= pg_next;
        u_reg       <= u_next;
        pp_reg      <= pp_next;
        b_reg       <= b_next;
        h_reg       <= h_next;
        tl_reg      <= tl_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_wa] <= next_wd;
        next_rd <= next_mem[u_reg];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        prev_rd <= prev_mem[prev_ra];
    end

    always_ff @(posedge clk)
    begin
        if (info_we)
        begin
            ord_mem[info_wa] <= ord_wd;
            hst_mem[info_wa] <= hst_wd;
        end
        ord_rd <= ord_mem[info_ra];
        hst_rd <= hst_mem[info_ra];
    end

    assign stat.clr_last  = (clr_reg == PGW'(NPAGES - 1));
    assign stat.is_free   = type_reg;
    assign stat.oversize  = ovs_reg;
    assign stat.bad_fmt   = bad_reg;
    assign stat.rel_empty = (head_sel == HEAD_EMPTY);
    assign stat.rel_last  = (rel_reg == ORD_TOP);
    assign stat.c_gt_req  = (c_reg > req_reg);
    assign stat.c_lt_top  = (c_reg < ORD_TOP);
    assign stat.pg_used   = (hst_rd == bpa_pkg::PG_USED);
    assign stat.buddy_ok  = (hst_rd == bpa_pkg::PG_FREE) && (ord_rd == c_reg);

    assign out_status  = status_reg;
    assign out_granted = granted_reg;

endmodule

>>> rtl/core/buddy_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over 2^TOP_ORDER bytes in pages of 2^PAGE_SHIFT bytes,
// one LIFO free list per order.
// ----------------------------------------------------------------------------
//  Channel   Dir  Word contents
//  s_axis    in   tuser: req_type; tdata: req_size, block_offset
//  m_axis    out  tdata: status, granted_offset
//
// One request at a time. Allocate: decode, a search step per order, unlink,
// a split and push per order split, grant, result word. Free: checks, per
// merge a buddy read, unlink and merge up; last buddy check, push, result.
// After reset a clearing pass runs over all 2^(TOP_ORDER-PAGE_SHIFT) pages
// of the link and page info memories before the first word is taken.
// The result word holds until taken; no new word is taken meanwhile.
// ----------------------------------------------------------------------------
module buddy_page_allocator
#(
    parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF,
    parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bpa_pkg::S_TDATA_W-1:0] s_tdata,  // req_size, block_offset
    input  logic [0:0]                    s_tuser,  // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bpa_pkg::M_TDATA_W-1:0] m_tdata   // status, granted_offset
);

    bpa_pkg::bpa_cmd_t          cmd;
    bpa_pkg::bpa_stat_t         stat;
    logic [bpa_pkg::STAT_W-1:0] res_status;
    logic [bpa_pkg::OFF_W-1:0]  res_granted;

    bpa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    bpa_dpath #(
        .PAGE_SHIFT (PAGE_SHIFT),
        .TOP_ORDER  (TOP_ORDER)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_type     (s_tuser[0]),
        .in_size     (s_tdata[bpa_pkg::SIZE_W-1:0]),
        .in_off      (s_tdata[bpa_pkg::SIZE_W +: bpa_pkg::OFF_W]),
        .out_status  (res_status),
        .out_granted (res_granted)
    );

    assign m_tdata = {2'b00, res_granted, res_status};

`ifndef NO_ASSERTIONS
    a_no_take_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_no_same_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result shown in the cycle after a request");

    a_zero_offset_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_status != bpa_pkg::ST_OK)) |-> (res_granted == '0))
        else $error("offset given with a failure status");

    a_op_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && !s_tvalid) |-> (cmd.op == bpa_pkg::OP_NONE))
        else $error("datapath command issued while idle");
`endif

endmodule

>>> tb/sv/tb_buddy_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_page_allocator
// Self-checking bench for the buddy page allocator: drives allocate and free
// requests with random gaps and stalls, predicts every result with a
// behavioural buddy model and checks the response words in order.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator;

    localparam int NPG  = 256;
    localparam int NORD = 9;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct packed {
        logic [bpa_pkg::STAT_W-1:0] status;
        logic [bpa_pkg::OFF_W-1:0]  offset;
    } resp_t;

    class alloc_scoreboard;
        int unsigned head[NORD];
        int unsigned nxt[NPG];
        int unsigned prv[NPG];
        int unsigned ord[NPG];
        logic [1:0]  hst[NPG];
        resp_t       pending[$];
        int          mismatches;
        int unsigned used_blocks[$];

        function void push_free(int unsigned r, int unsigned p);
            int unsigned h;
            int unsigned t;
            h = head[r];
            if (h == NPG)
            begin
                nxt[p] = p;
                prv[p] = p;
            end
            else
            begin
                t = prv[h];
                nxt[p] = h;
                prv[p] = t;
                nxt[t] = p;
                prv[h] = p;
            end
            head[r] = p;
        endfunction

        function void unlink_free(int unsigned r, int unsigned p);
            int unsigned n;
            int unsigned q;
            n = nxt[p];
            q = prv[p];
            if (n == p)
            begin
                head[r] = NPG;
                return;
            end
            nxt[q] = n;
            prv[n] = q;
            if (head[r] == p)
                head[r] = n;
        endfunction

        function void clear();
            for (int i = 0; i < NORD; i++)
                head[i] = NPG;
            for (int i = 0; i < NPG; i++)
            begin
                ord[i] = 0;
                hst[i] = bpa_pkg::PG_NONE;
            end
            ord[0] = NORD - 1;
            hst[0] = bpa_pkg::PG_FREE;
            push_free(NORD - 1, 0);
            mismatches = 0;
        endfunction

        function void note_request(logic is_free, logic [bpa_pkg::SIZE_W-1:0] size,
                                   logic [bpa_pkg::OFF_W-1:0] off);
            resp_t       r;
            int unsigned rq;
            int unsigned t;
            int unsigned p;
            int unsigned c;
            int unsigned b;
            bit          found;
            r = '0;
            if (!is_free)
            begin
                if (size > 21'd1048576)
                    r.status = bpa_pkg::ST_NOSPACE;
                else
                begin
                    rq = 0;
                    while (rq < NORD - 1 && (64'd1 << (rq + 12)) < size)
                        rq++;
                    found = 0;
                    for (t = rq; t < NORD; t++)
                        if (head[t] != NPG)
                        begin
                            found = 1;
                            break;
                        end
                    if (!found)
                        r.status = bpa_pkg::ST_NOSPACE;
                    else
                    begin
                        p = head[t];
                        unlink_free(t, p);
                        for (c = t; c > rq; c--)
                        begin
                            b = p ^ (1 << (c - 1));
                            ord[b] = c - 1;
                            hst[b] = bpa_pkg::PG_FREE;
                            push_free(c - 1, b);
                        end
                        ord[p] = rq;
                        hst[p] = bpa_pkg::PG_USED;
                        r.offset = bpa_pkg::OFF_W'(p << 12);
                        used_blocks.push_back(p);
                    end
                end
            end
            else if (off[11:0] != 0 || hst[off >> 12] != bpa_pkg::PG_USED)
                r.status = bpa_pkg::ST_BADFREE;
            else
            begin
                p = off >> 12;
                c = ord[p];
                hst[p] = bpa_pkg::PG_NONE;
                foreach (used_blocks[i])
                    if (used_blocks[i] == p)
                    begin
                        used_blocks.delete(i);
                        break;
                    end
                while (c < NORD - 1)
                begin
                    b = p ^ (1 << c);
                    if (hst[b] != bpa_pkg::PG_FREE || ord[b] != c)
                        break;
                    unlink_free(c, b);
                    hst[b] = bpa_pkg::PG_NONE;
                    if (b < p)
                        p = b;
                    c++;
                end
                ord[p] = c;
                hst[p] = bpa_pkg::PG_FREE;
                push_free(c, p);
            end
            pending.push_back(r);
        endfunction

        function void check_response(logic [bpa_pkg::M_TDATA_W-1:0] word);
            resp_t got;
            resp_t exp_r;
            // status sits in the low bits of the word, offset above it
            got = {word[bpa_pkg::STAT_W-1:0],
                   word[bpa_pkg::STAT_W+bpa_pkg::OFF_W-1:bpa_pkg::STAT_W]};
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: status %0d offset %h",
                             got.status, got.offset);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r ||
                word[bpa_pkg::M_TDATA_W-1:bpa_pkg::STAT_W+bpa_pkg::OFF_W] !== '0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response mismatch: expected status %0d offset %h, got %0d %h",
                             exp_r.status, exp_r.offset, got.status, got.offset);
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [bpa_pkg::S_TDATA_W-1:0] s_tdata;
    logic [0:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [bpa_pkg::M_TDATA_W-1:0] m_tdata;

    alloc_scoreboard sb;
    int unsigned     cycle_count = 0;
    int              out_wait;

    buddy_page_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // send one request word, after a random gap; valid drops only for a gap
    task automatic send_request(logic is_free, logic [bpa_pkg::SIZE_W-1:0] size,
                                logic [bpa_pkg::OFF_W-1:0] off);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_free;
        s_tdata  <= {7'd0, off, size};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(is_free, size, off);
    endtask

    task automatic send_alloc(logic [bpa_pkg::SIZE_W-1:0] size);
        send_request(1'b0, size, bpa_pkg::OFF_W'($urandom));
    endtask

    task automatic send_free(logic [bpa_pkg::OFF_W-1:0] off);
        send_request(1'b1, bpa_pkg::SIZE_W'($urandom), off);
    endtask

    // pick a size biased to small orders, with occasional large ones
    function automatic logic [bpa_pkg::SIZE_W-1:0] rand_size();
        int k;
        k = $urandom_range(0, 99);
        if (k < 3)
            return bpa_pkg::SIZE_W'($urandom);
        if (k < 8)
            return bpa_pkg::SIZE_W'($urandom_range(262145, 1048576));
        return bpa_pkg::SIZE_W'($urandom_range(0, 32768));
    endfunction

    // response side: after every word taken, drop ready and raise it again after a random wait
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            sb.check_response(m_tdata);
            out_wait <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else if (!m_tready)
        begin
            if (out_wait <= 1)
                m_tready <= 1'b1;
            else
                out_wait <= out_wait - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("buddy_page_allocator regression: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned p;
        int          k;
        sb = new();
        sb.clear();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed: sizes at order edges, whole region, oversize, bad frees
        send_alloc(21'd1048576);
        send_alloc(21'd0);
        send_free(20'd0);
        send_free(20'd0);
        send_alloc(21'd0);
        send_alloc(21'd1);
        send_alloc(21'd4096);
        send_alloc(21'd4097);
        send_alloc(21'd1048577);
        send_alloc(21'h1FFFFF);
        send_alloc(21'd262144);
        send_alloc(21'd524288);
        send_free(20'd4095);
        send_free(20'hFFFFF);
        send_free(20'hFF000);
        while (sb.used_blocks.size() > 0)
            send_free(bpa_pkg::OFF_W'(sb.used_blocks[0] << 12));
        send_alloc(21'd1048576);
        send_free(20'd0);

        // random: mostly well-formed alloc/free traffic, some noise
        for (int i = 0; i < 1030; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 50)
                send_alloc(rand_size());
            else if (k < 90 && sb.used_blocks.size() > 0)
            begin
                p = sb.used_blocks[$urandom_range(0, sb.used_blocks.size() - 1)];
                send_free(bpa_pkg::OFF_W'(p << 12));
            end
            else if (k < 95)
                send_free(bpa_pkg::OFF_W'($urandom_range(0, 255) << 12));
            else
                send_free(bpa_pkg::OFF_W'($urandom));
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("buddy_page_allocator regression: pass");
        else
            $display("buddy_page_allocator regression: fail");
        $finish;
    end

endmodule
